[rtl/amu_pkg.sv]
// ----------------------------------------------------------------------------
// Alarm unit package
// Types and constants shared by the modules of the multi-channel alarm unit.
// ----------------------------------------------------------------------------
package amu_pkg;

	localparam int unsigned MODE_W   = 2;
	localparam int unsigned CHAN_W   = 3;
	localparam int unsigned COUNT_W  = 16;
	localparam int unsigned MASK_W   = 8;
	localparam int unsigned ENTRY_W  = 2 * COUNT_W;

	localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_OPEN  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLOSE = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_EMIT
	} amu_state_t;

	typedef struct packed {
		logic              valid;
		logic [MASK_W-1:0] fired_mask;
	} amu_res_t;

endpackage

[rtl/amu_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module amu_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 8
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/amu_seq.sv]
// ----------------------------------------------------------------------------
// Alarm unit sequencer
// Handles open and close requests and sweeps the channel table one channel
// per cycle through a shared increment and compare unit on each tick.
// ----------------------------------------------------------------------------
module amu_seq #(
	parameter int unsigned CHANNELS = 8
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          in_valid,
	output logic                                          in_ready,
	input  logic [amu_pkg::MODE_W-1:0]                    mode,
	input  logic [amu_pkg::CHAN_W-1:0]                    channel,
	input  logic [amu_pkg::COUNT_W-1:0]                   period,
	output logic                                          ram_we,
	output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] ram_waddr,
	output logic [amu_pkg::ENTRY_W-1:0]                   ram_wdata,
	output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] ram_raddr,
	input  logic [amu_pkg::ENTRY_W-1:0]                   ram_rdata,
	output amu_pkg::amu_res_t                             res,
	input  logic                                          res_ready
);

	localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [amu_pkg::MASK_W-1:0] CH_MASK =
		(CHANNELS >= amu_pkg::MASK_W) ? {amu_pkg::MASK_W{1'b1}}
		: amu_pkg::MASK_W'((64'd1 << CHANNELS) - 64'd1);

	amu_pkg::amu_state_t state_q, state_d;

	logic [CHANNELS-1:0]              active_q;
	logic [CW-1:0]                    idx_q;
	logic [amu_pkg::MASK_W-1:0]       mask_q;
	logic [CW-1:0]                    ch_addr;
	logic                             ch_ok;
	logic                             accept;
	logic                             last;
	logic                             in_mask;
	logic [amu_pkg::COUNT_W-1:0]      cur_period;
	logic [amu_pkg::COUNT_W-1:0]      cur_elapsed;
	logic [amu_pkg::COUNT_W-1:0]      inc;
	logic                             hit;

	assign ch_addr     = CW'(channel);
	assign ch_ok       = 32'(channel) < CHANNELS;
	assign accept      = in_valid && in_ready;
	assign last        = idx_q == CW'(CHANNELS - 1);
	assign in_mask     = 32'(idx_q) < amu_pkg::MASK_W;
	assign cur_period  = ram_rdata[amu_pkg::ENTRY_W-1:amu_pkg::COUNT_W];
	assign cur_elapsed = ram_rdata[amu_pkg::COUNT_W-1:0];
	assign inc         = cur_elapsed + amu_pkg::COUNT_W'(1);
	assign hit         = inc == cur_period;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= amu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = idx_q;
		ram_wdata  = {cur_period, inc};
		ram_raddr  = '0;
		res.valid  = 1'b0;
		res.fired_mask = mask_q;
		unique case (state_q)
			amu_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (mode == amu_pkg::MODE_TICK) begin
						state_d = amu_pkg::ST_SWEEP;
					end else if (mode == amu_pkg::MODE_OPEN && ch_ok) begin
						ram_we    = 1'b1;
						ram_waddr = ch_addr;
						ram_wdata = {period, amu_pkg::COUNT_W'(0)};
					end
				end
			end
			amu_pkg::ST_SWEEP: begin
				ram_raddr = idx_q + CW'(1);
				if (active_q[idx_q]) begin
					ram_we = 1'b1;
					if (hit) begin
						ram_wdata = {cur_period, amu_pkg::COUNT_W'(0)};
					end
				end
				if (last) begin
					state_d = amu_pkg::ST_EMIT;
				end
			end
			amu_pkg::ST_EMIT: begin
				res.valid = 1'b1;
				if (res_ready) begin
					state_d = amu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = amu_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			idx_q    <= '0;
			mask_q   <= '0;
		end else begin
			if (state_q == amu_pkg::ST_IDLE && accept) begin
				if (mode == amu_pkg::MODE_TICK) begin
					idx_q  <= '0;
					mask_q <= '0;
				end else if (mode == amu_pkg::MODE_OPEN && ch_ok) begin
					active_q[ch_addr] <= 1'b1;
				end else if (mode == amu_pkg::MODE_CLOSE && ch_ok) begin
					active_q[ch_addr] <= 1'b0;
				end
			end
			if (state_q == amu_pkg::ST_SWEEP) begin
				idx_q <= idx_q + CW'(1);
				if (active_q[idx_q] && hit) begin
					active_q[idx_q] <= 1'b0;
					if (in_mask) begin
						mask_q[3'(idx_q)] <= 1'b1;
					end
				end
			end
		end
	end

	a_tick_starts_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == amu_pkg::ST_IDLE && accept && mode == amu_pkg::MODE_TICK)
		|=> (state_q == amu_pkg::ST_SWEEP && idx_q == '0 && mask_q == '0))
		else $error("sweep did not start from the first channel with a clear mask");

	a_mask_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> ((res.fired_mask & ~CH_MASK) == '0))
		else $error("fired mask names a channel that does not exist");

	a_fire_deactivates: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == amu_pkg::ST_SWEEP && active_q[idx_q] && hit)
		|=> !active_q[$past(idx_q)])
		else $error("fired channel is still active");

	a_sweep_ends_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == amu_pkg::ST_SWEEP && last) |=> state_q == amu_pkg::ST_EMIT)
		else $error("sweep did not hand over its result");

endmodule

[rtl/multi_channel_one_shot_alarm_unit.sv]
// ----------------------------------------------------------------------------
// Multi-channel one-shot alarm unit
// A table of one-shot alarm channels driven by open, close and tick requests.
// ----------------------------------------------------------------------------
// Usage: an input request carries mode, channel and period under in_valid and
// in_ready. An open request loads a channel's period, clears its count and
// arms it; a close request disarms it. Both give no result.
// A tick request makes the sequencer sweep the channel table held in a RAM,
// one channel per cycle through a single increment and compare unit: every
// armed channel counts, and a channel whose count reaches its period fires
// and disarms. The tick yields one result, fired_mask, on out_valid and
// out_ready, with one bit for each of the first eight channels.
// The result of a tick is written to the output register from the EMIT state
// at the end of the sweep over the RAM read port. The input is not ready
// during the sweep and the hand-over of its result, so a new tick is taken
// only after the last one has handed over its result. An open or close
// request may follow the tick result while it still waits in the output
// register; a stalled receiver holds the next tick at the end of its sweep
// until the register frees.
// Reset disarms every channel and empties the output register.
// ----------------------------------------------------------------------------
module multi_channel_one_shot_alarm_unit #(
	parameter int unsigned CHANNELS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [amu_pkg::MODE_W-1:0]        mode,
	input  logic [amu_pkg::CHAN_W-1:0]        channel,
	input  logic [amu_pkg::COUNT_W-1:0]       period,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [amu_pkg::MASK_W-1:0]        fired_mask
);

	localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic                          ram_we;
	logic [CW-1:0]                 ram_waddr;
	logic [amu_pkg::ENTRY_W-1:0]   ram_wdata;
	logic [CW-1:0]                 ram_raddr;
	logic [amu_pkg::ENTRY_W-1:0]   ram_rdata;
	amu_pkg::amu_res_t             res;
	logic                          res_ready;
	logic                          out_valid_q;
	logic [amu_pkg::MASK_W-1:0]    fired_mask_q;

	amu_ram #(
		.WIDTH (amu_pkg::ENTRY_W),
		.DEPTH (CHANNELS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	amu_seq #(
		.CHANNELS (CHANNELS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.channel   (channel),
		.period    (period),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.res       (res),
		.res_ready (res_ready)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			fired_mask_q <= res.fired_mask;
		end
	end

	assign out_valid  = out_valid_q;
	assign fired_mask = fired_mask_q;

endmodule
